/* src/tlma_pkg.sv */
// package: shared codes, command/status structs and saturation helpers
`timescale 1ns / 1ps
`default_nettype none
package tlma_pkg;

    typedef enum logic [1:0] {
        KIND_GLYPH   = 2'd0,
        KIND_NEWLINE = 2'd1,
        KIND_TAB     = 2'd2,
        KIND_MISSING = 2'd3
    } t_char_kind;

    typedef enum logic [1:0] {
        ALIGN_LEFT   = 2'd0,
        ALIGN_RIGHT  = 2'd1,
        ALIGN_CENTER = 2'd2,
        ALIGN_UNDEF  = 2'd3
    } t_align;

    typedef enum logic [1:0] {
        CFG_ALIGN_MODE    = 2'd0,
        CFG_TEXT_SIZE     = 2'd1,
        CFG_WIDTH_FACTOR  = 2'd2,
        CFG_HEIGHT_FACTOR = 2'd3
    } t_cfg_index;

    localparam logic RES_LINE = 1'b0;
    localparam logic RES_BOX  = 1'b1;

    localparam int CFG_W     = 26;
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH,
        S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7,
        S_UPD_A, S_UPD_B,
        S_TAB, S_DIV, S_TAB_MUL, S_TAB_CAP,
        S_DONE, S_LINE, S_BOX_PREP, S_BOX
    } t_state;

    typedef enum logic [3:0] {
        MUL_NONE, MUL_OX, MUL_OY, MUL_ADV, MUL_WX, MUL_WT, MUL_HY, MUL_HT, MUL_TAB
    } t_mul_sel;

    typedef enum logic [2:0] {
        CAP_NONE, CAP_OX, CAP_OY, CAP_ADV, CAP_T, CAP_W, CAP_H, CAP_TAB
    } t_cap_sel;

    typedef struct packed {
        logic     in_ready;
        t_mul_sel mul_sel;
        t_cap_sel cap_sel;
        logic     upd_a;
        logic     upd_b;
        logic     zero_pen;
        logic     div_init;
        logic     div_step;
        logic     load_line;
        logic     box_prep;
        logic     load_box;
    } t_cmd;

    typedef struct packed {
        t_char_kind kind;
        logic       last;
        logic       step_zero;
        logic       out_busy;
    } t_status;

    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX) r = 32'sh7FFF_FFFF;
        else if (v < SAT_MIN) r = 32'sh8000_0000;
        else r = v[31:0];
        return r;
    endfunction

    // shift of a line or box of the given (non-negative) width
    function automatic logic signed [31:0] align_shift(input logic [1:0] mode,
                                                       input logic signed [33:0] width);
        logic signed [31:0] r;
        case (mode)
            ALIGN_RIGHT:  r = sat32(-64'(width));
            ALIGN_CENTER: r = sat32(-64'(width >>> 1));
            default:      r = 32'sd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

/* src/tlma_if.sv */
// interfaces: character input channel and result output channel
`timescale 1ns / 1ps
`default_nettype none
interface tlma_in_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  char_kind;
    logic        [16:0] glyph_scale_x;
    logic        [16:0] glyph_scale_y;
    logic signed [31:0] glyph_offset_x;
    logic signed [31:0] glyph_offset_y;
    logic signed [31:0] glyph_advance;
    logic               last_char;

    modport source (output valid, char_kind, glyph_scale_x, glyph_scale_y,
                    glyph_offset_x, glyph_offset_y, glyph_advance, last_char,
                    input ready);
    modport sink (input valid, char_kind, glyph_scale_x, glyph_scale_y,
                  glyph_offset_x, glyph_offset_y, glyph_advance, last_char,
                  output ready);
endinterface

interface tlma_out_if;
    logic               valid;
    logic               ready;
    logic               result_kind;
    logic signed [31:0] line_offset;
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic               last_result;

    modport source (output valid, result_kind, line_offset, box_min_x, box_min_y,
                    box_max_x, box_max_y, last_result, input ready);
    modport sink (input valid, result_kind, line_offset, box_min_x, box_min_y,
                  box_max_x, box_max_y, last_result, output ready);
endinterface
`default_nettype wire

/* src/tlma_ctrl.sv */
// controller: sequences multiplies, tab division and result loads
`timescale 1ns / 1ps
`default_nettype none
module tlma_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_accept,
    input  tlma_pkg::t_status i_status,
    output tlma_pkg::t_cmd   o_cmd
);

    tlma_pkg::t_state r_state, n_state;
    logic [tlma_pkg::DIV_CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tlma_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            tlma_pkg::S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_accept) n_state = tlma_pkg::S_DISPATCH;
            end
            tlma_pkg::S_DISPATCH: begin
                unique case (i_status.kind)
                    tlma_pkg::KIND_GLYPH: n_state = tlma_pkg::S_M0;
                    tlma_pkg::KIND_TAB:   n_state = tlma_pkg::S_TAB;
                    default:              n_state = tlma_pkg::S_DONE;
                endcase
            end
            // glyph: one multiply issued per cycle, captured the next
            tlma_pkg::S_M0: begin
                o_cmd.mul_sel = tlma_pkg::MUL_OX;
                n_state = tlma_pkg::S_M1;
            end
            tlma_pkg::S_M1: begin
                o_cmd.cap_sel = tlma_pkg::CAP_OX;
                o_cmd.mul_sel = tlma_pkg::MUL_WX;
                n_state = tlma_pkg::S_M2;
            end
            tlma_pkg::S_M2: begin
                o_cmd.cap_sel = tlma_pkg::CAP_T;
                o_cmd.mul_sel = tlma_pkg::MUL_OY;
                n_state = tlma_pkg::S_M3;
            end
            tlma_pkg::S_M3: begin
                o_cmd.cap_sel = tlma_pkg::CAP_OY;
                o_cmd.mul_sel = tlma_pkg::MUL_WT;
                n_state = tlma_pkg::S_M4;
            end
            tlma_pkg::S_M4: begin
                o_cmd.cap_sel = tlma_pkg::CAP_W;
                o_cmd.mul_sel = tlma_pkg::MUL_HY;
                n_state = tlma_pkg::S_M5;
            end
            tlma_pkg::S_M5: begin
                o_cmd.cap_sel = tlma_pkg::CAP_T;
                o_cmd.mul_sel = tlma_pkg::MUL_ADV;
                n_state = tlma_pkg::S_M6;
            end
            tlma_pkg::S_M6: begin
                o_cmd.cap_sel = tlma_pkg::CAP_ADV;
                o_cmd.mul_sel = tlma_pkg::MUL_HT;
                n_state = tlma_pkg::S_M7;
            end
            tlma_pkg::S_M7: begin
                o_cmd.cap_sel = tlma_pkg::CAP_H;
                n_state = tlma_pkg::S_UPD_A;
            end
            tlma_pkg::S_UPD_A: begin
                o_cmd.upd_a = 1'b1;
                n_state = tlma_pkg::S_UPD_B;
            end
            tlma_pkg::S_UPD_B: begin
                o_cmd.upd_b = 1'b1;
                n_state = tlma_pkg::S_DONE;
            end
            tlma_pkg::S_TAB: begin
                if (i_status.step_zero) begin
                    o_cmd.zero_pen = 1'b1;
                    n_state = tlma_pkg::S_DONE;
                end else begin
                    o_cmd.div_init = 1'b1;
                    n_cnt   = tlma_pkg::DIV_CNT_W'(tlma_pkg::DIV_STEPS);
                    n_state = tlma_pkg::S_DIV;
                end
            end
            tlma_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == tlma_pkg::DIV_CNT_W'(1)) n_state = tlma_pkg::S_TAB_MUL;
            end
            tlma_pkg::S_TAB_MUL: begin
                o_cmd.mul_sel = tlma_pkg::MUL_TAB;
                n_state = tlma_pkg::S_TAB_CAP;
            end
            tlma_pkg::S_TAB_CAP: begin
                o_cmd.cap_sel = tlma_pkg::CAP_TAB;
                n_state = tlma_pkg::S_DONE;
            end
            tlma_pkg::S_DONE: begin
                if ((i_status.kind == tlma_pkg::KIND_GLYPH && i_status.last) ||
                    i_status.kind == tlma_pkg::KIND_NEWLINE)
                    n_state = tlma_pkg::S_LINE;
                else if (i_status.last)
                    n_state = tlma_pkg::S_BOX_PREP;
                else
                    n_state = tlma_pkg::S_IDLE;
            end
            tlma_pkg::S_LINE: begin
                if (!i_status.out_busy) begin
                    o_cmd.load_line = 1'b1;
                    n_state = i_status.last ? tlma_pkg::S_BOX_PREP : tlma_pkg::S_IDLE;
                end
            end
            tlma_pkg::S_BOX_PREP: begin
                o_cmd.box_prep = 1'b1;
                n_state = tlma_pkg::S_BOX;
            end
            tlma_pkg::S_BOX: begin
                if (!i_status.out_busy) begin
                    o_cmd.load_box = 1'b1;
                    n_state = tlma_pkg::S_IDLE;
                end
            end
            default: n_state = tlma_pkg::S_IDLE;
        endcase
    end

    property p_cnt_only_in_div;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> (r_state == tlma_pkg::S_DIV);
    endproperty
    a_cnt_only_in_div: assert property (p_cnt_only_in_div)
        else $error("division counter running outside division");

    property p_accept_leaves_idle;
        @(posedge i_clk) disable iff (!i_rst_n)
        i_accept |=> (r_state == tlma_pkg::S_DISPATCH);
    endproperty
    a_accept_leaves_idle: assert property (p_accept_leaves_idle)
        else $error("accepted word not dispatched");

    property p_box_then_idle;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tlma_pkg::S_BOX && !i_status.out_busy) |=> (r_state == tlma_pkg::S_IDLE);
    endproperty
    a_box_then_idle: assert property (p_box_then_idle)
        else $error("box load did not end the word");

endmodule
`default_nettype wire

/* src/tlma_dp.sv */
// datapath: config, layout state, shared multiplier, divider, output register
`timescale 1ns / 1ps
`default_nettype none
module tlma_dp #(
    parameter int FRAC_BITS = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_we,
    input  wire  [1:0]                  i_cfg_index,
    input  wire  [tlma_pkg::CFG_W-1:0]  i_cfg_data,
    input  wire                         i_accept,
    input  wire  [1:0]                  i_char_kind,
    input  wire  [16:0]                 i_glyph_scale_x,
    input  wire  [16:0]                 i_glyph_scale_y,
    input  wire  signed [31:0]          i_glyph_offset_x,
    input  wire  signed [31:0]          i_glyph_offset_y,
    input  wire  signed [31:0]          i_glyph_advance,
    input  wire                         i_last_char,
    input  tlma_pkg::t_cmd              i_cmd,
    output tlma_pkg::t_status           o_status,
    input  wire                         i_out_ready,
    output logic                        o_out_valid,
    output logic                        o_result_kind,
    output logic signed [31:0]          o_line_offset,
    output logic signed [31:0]          o_box_min_x,
    output logic signed [31:0]          o_box_min_y,
    output logic signed [31:0]          o_box_max_x,
    output logic signed [31:0]          o_box_max_y,
    output logic                        o_last_result
);

    localparam logic [63:0] TS_RESET_W = 64'(16) << FRAC_BITS;
    localparam logic [63:0] FACT_RESET_W = 64'(1) << FRAC_BITS;
    localparam logic [tlma_pkg::CFG_W-1:0] TS_RESET = TS_RESET_W[tlma_pkg::CFG_W-1:0];
    localparam logic [tlma_pkg::CFG_W-1:0] FACT_RESET = FACT_RESET_W[tlma_pkg::CFG_W-1:0];

    logic [1:0]                 r_align;
    logic [tlma_pkg::CFG_W-1:0] r_ts, r_wf, r_hf;

    tlma_pkg::t_char_kind r_kind;
    logic [16:0]          r_sx, r_sy;
    logic signed [31:0]   r_oxi, r_oyi, r_advi;
    logic                 r_last;

    logic signed [31:0] r_ox, r_oy, r_w, r_h, r_adv, r_x0, r_y0, r_bshift;
    logic [26:0]        r_t;

    logic signed [31:0] r_pen_x, r_pen_y, r_line_left, r_line_right;
    logic signed [31:0] r_bmin_x, r_bmin_y, r_bmax_x, r_bmax_y;

    logic signed [60:0] r_prod;
    logic [27:0]        r_rem;
    logic [31:0]        r_quo;
    logic               r_neg;

    logic [27:0] step;
    assign step = {1'b0, r_ts, 1'b0};

    // multiplier operand select
    logic signed [32:0] mul_a, q_signed, q_plus1;
    logic signed [27:0] mul_b;
    assign q_signed = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    assign q_plus1  = q_signed + 33'sd1;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.mul_sel)
            tlma_pkg::MUL_OX:  begin mul_a = {r_oxi[31], r_oxi};   mul_b = {2'b0, r_ts}; end
            tlma_pkg::MUL_OY:  begin mul_a = {r_oyi[31], r_oyi};   mul_b = {2'b0, r_ts}; end
            tlma_pkg::MUL_ADV: begin mul_a = {r_advi[31], r_advi}; mul_b = {2'b0, r_ts}; end
            tlma_pkg::MUL_WX:  begin mul_a = {16'b0, r_sx};        mul_b = {2'b0, r_wf}; end
            tlma_pkg::MUL_HY:  begin mul_a = {16'b0, r_sy};        mul_b = {2'b0, r_hf}; end
            tlma_pkg::MUL_WT,
            tlma_pkg::MUL_HT:  begin mul_a = {6'b0, r_t};          mul_b = {2'b0, r_ts}; end
            tlma_pkg::MUL_TAB: begin mul_a = q_plus1;              mul_b = $signed(step); end
            default: ;
        endcase
    end

    // floor shift then saturate
    logic signed [60:0] prod_sh;
    logic signed [31:0] prod_fl;
    assign prod_sh = r_prod >>> FRAC_BITS;
    assign prod_fl = tlma_pkg::sat32(64'(prod_sh));

    // glyph span
    logic signed [31:0] x0_n, y0_n, x1_n, y1_n, pen_adv;
    assign x0_n    = tlma_pkg::sat32(64'(r_pen_x) + 64'(r_ox));
    assign y0_n    = tlma_pkg::sat32(64'(r_pen_y) + 64'(r_oy));
    assign x1_n    = tlma_pkg::sat32(64'(r_x0) + 64'(r_w));
    assign y1_n    = tlma_pkg::sat32(64'(r_y0) + 64'(r_h));
    assign pen_adv = tlma_pkg::sat32(64'(r_pen_x) + 64'(r_adv));

    // restoring divider step
    logic [27:0] trial;
    assign trial = {r_rem[26:0], r_quo[31]};

    logic signed [33:0] line_width, box_width;
    assign line_width = 34'(r_line_right) - 34'(r_line_left);
    assign box_width  = 34'(r_bmax_x) - 34'(r_bmin_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_align <= tlma_pkg::ALIGN_LEFT;
            r_ts    <= TS_RESET;
            r_wf    <= FACT_RESET;
            r_hf    <= FACT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tlma_pkg::CFG_ALIGN_MODE:   r_align <= i_cfg_data[1:0];
                tlma_pkg::CFG_TEXT_SIZE:    r_ts    <= i_cfg_data;
                tlma_pkg::CFG_WIDTH_FACTOR: r_wf    <= i_cfg_data;
                default:                    r_hf    <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_kind <= tlma_pkg::t_char_kind'(i_char_kind);
            r_sx   <= i_glyph_scale_x;
            r_sy   <= i_glyph_scale_y;
            r_oxi  <= i_glyph_offset_x;
            r_oyi  <= i_glyph_offset_y;
            r_advi <= i_glyph_advance;
            r_last <= i_last_char;
        end
        r_prod <= mul_a * mul_b;
        case (i_cmd.cap_sel)
            tlma_pkg::CAP_OX:  r_ox  <= prod_fl;
            tlma_pkg::CAP_OY:  r_oy  <= prod_fl;
            tlma_pkg::CAP_ADV: r_adv <= prod_fl;
            tlma_pkg::CAP_T:   r_t   <= r_prod[42:16];
            tlma_pkg::CAP_W:   r_w   <= prod_fl;
            tlma_pkg::CAP_H:   r_h   <= prod_fl;
            default: ;
        endcase
        if (i_cmd.upd_a) begin
            r_x0 <= x0_n;
            r_y0 <= y0_n;
        end
        if (i_cmd.div_init) begin
            r_neg <= r_pen_x[31];
            r_quo <= r_pen_x[31] ? 32'(-r_pen_x) : r_pen_x;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            if (trial >= step) begin
                r_rem <= trial - step;
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= trial;
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
        if (i_cmd.box_prep) r_bshift <= tlma_pkg::align_shift(r_align, box_width);
    end

    // layout state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_x      <= '0;
            r_pen_y      <= '0;
            r_line_left  <= '0;
            r_line_right <= '0;
            r_bmin_x     <= '0;
            r_bmin_y     <= '0;
            r_bmax_x     <= '0;
            r_bmax_y     <= '0;
            o_out_valid  <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) o_out_valid <= 1'b0;
            if (i_cmd.cap_sel == tlma_pkg::CAP_TAB) r_pen_x <= tlma_pkg::sat32(64'(r_prod));
            if (i_cmd.zero_pen) r_pen_x <= '0;
            if (i_cmd.upd_b) begin
                if (r_x0 < r_line_left)  r_line_left  <= r_x0;
                if (x1_n > r_line_right) r_line_right <= x1_n;
                if (r_x0 < r_bmin_x)     r_bmin_x     <= r_x0;
                if (x1_n > r_bmax_x)     r_bmax_x     <= x1_n;
                if (r_y0 < r_bmin_y)     r_bmin_y     <= r_y0;
                if (y1_n > r_bmax_y)     r_bmax_y     <= y1_n;
                r_pen_x <= pen_adv;
            end
            if (i_cmd.load_line) begin
                o_out_valid   <= 1'b1;
                o_result_kind <= tlma_pkg::RES_LINE;
                o_line_offset <= tlma_pkg::align_shift(r_align, line_width);
                o_box_min_x   <= '0;
                o_box_min_y   <= '0;
                o_box_max_x   <= '0;
                o_box_max_y   <= '0;
                o_last_result <= !r_last;
                if (r_kind == tlma_pkg::KIND_NEWLINE) begin
                    r_line_left  <= '0;
                    r_line_right <= '0;
                    r_pen_x      <= '0;
                    r_pen_y      <= tlma_pkg::sat32(64'(r_pen_y) + 64'(r_ts));
                end
            end
            if (i_cmd.load_box) begin
                o_out_valid   <= 1'b1;
                o_result_kind <= tlma_pkg::RES_BOX;
                o_line_offset <= '0;
                o_box_min_x   <= tlma_pkg::sat32(64'(r_bmin_x) + 64'(r_bshift));
                o_box_min_y   <= r_bmin_y;
                o_box_max_x   <= tlma_pkg::sat32(64'(r_bmax_x) + 64'(r_bshift));
                o_box_max_y   <= r_bmax_y;
                o_last_result <= 1'b1;
                r_pen_x      <= '0;
                r_pen_y      <= '0;
                r_line_left  <= '0;
                r_line_right <= '0;
                r_bmin_x     <= '0;
                r_bmin_y     <= '0;
                r_bmax_x     <= '0;
                r_bmax_y     <= '0;
            end
        end
    end

    assign o_status.kind      = r_kind;
    assign o_status.last      = r_last;
    assign o_status.step_zero = (r_ts == '0);
    assign o_status.out_busy  = o_out_valid;

    property p_line_extent;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_line_left <= 32'sd0) && (r_line_right >= 32'sd0);
    endproperty
    a_line_extent: assert property (p_line_extent)
        else $error("line extent does not contain the origin");

    property p_box_extent;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_bmin_x <= 32'sd0) && (r_bmax_x >= 32'sd0) &&
        (r_bmin_y <= 32'sd0) && (r_bmax_y >= 32'sd0);
    endproperty
    a_box_extent: assert property (p_box_extent)
        else $error("bounding box does not contain the origin");

    property p_line_word_box_zero;
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind == tlma_pkg::RES_LINE) |->
            (o_box_min_x == 32'sd0 && o_box_max_x == 32'sd0 &&
             o_box_min_y == 32'sd0 && o_box_max_y == 32'sd0);
    endproperty
    a_line_word_box_zero: assert property (p_line_word_box_zero)
        else $error("line word carries box fields");

    property p_no_load_when_busy;
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_line || i_cmd.load_box) |-> !o_out_valid;
    endproperty
    a_no_load_when_busy: assert property (p_no_load_when_busy)
        else $error("output register overwritten");

endmodule
`default_nettype wire

/* src/text_line_measure_align_unit.sv */
// top level: text line measurement and alignment unit
// usage
//   i_in carries one character word per handshake: kind, glyph metrics and a
//   last flag. o_out carries result words: a line alignment offset or the
//   final bounding box, each with last_result set on the word that ends the
//   results of its input character.
//   the configuration port writes align mode, text size and the width and
//   height factors; write it only while the unit is idle.
// sequencing
//   one character at a time; ready is high only in the idle state.
//   glyph: seven metric products through the one shared multiplier (one
//   product issued per cycle), then two update steps. tab: the 32-step
//   restoring divider finds the tab stop, then one multiply; a zero text
//   size skips both and clears the pen. a line word adds a load step,
//   the box word a shift and then a load; a final glyph gives both words.
// reset
//   synchronous, active low: registers return to their defaults, pen, line
//   extent and box clear, the output register empties.
// stall
//   results sit in one output register; a new character is taken while a
//   word waits, and the unit holds before loading a further word until the
//   receiver has taken the pending one.
`timescale 1ns / 1ps
`default_nettype none
module text_line_measure_align_unit #(
    parameter int FRAC_BITS = 16
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_cfg_we,
    input  wire [1:0]                  i_cfg_index,
    input  wire [tlma_pkg::CFG_W-1:0]  i_cfg_data,
    tlma_in_if.sink                    i_in,
    tlma_out_if.source                 o_out
);

    tlma_pkg::t_cmd    cmd;
    tlma_pkg::t_status status;
    logic              accept;

    // word accepted from the input channel
    assign i_in.ready = cmd.in_ready;
    assign accept     = i_in.valid && cmd.in_ready;

    tlma_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_status (status),
        .o_cmd    (cmd)
    );

    tlma_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_accept         (accept),
        .i_char_kind      (i_in.char_kind),
        .i_glyph_scale_x  (i_in.glyph_scale_x),
        .i_glyph_scale_y  (i_in.glyph_scale_y),
        .i_glyph_offset_x (i_in.glyph_offset_x),
        .i_glyph_offset_y (i_in.glyph_offset_y),
        .i_glyph_advance  (i_in.glyph_advance),
        .i_last_char      (i_in.last_char),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_out_ready      (o_out.ready),
        .o_out_valid      (o_out.valid),
        .o_result_kind    (o_out.result_kind),
        .o_line_offset    (o_out.line_offset),
        .o_box_min_x      (o_out.box_min_x),
        .o_box_min_y      (o_out.box_min_y),
        .o_box_max_x      (o_out.box_max_x),
        .o_box_max_y      (o_out.box_max_y),
        .o_last_result    (o_out.last_result)
    );

endmodule
`default_nettype wire

/* tb/sv/tb_text_line_measure_align_unit.sv */
// testbench: random and directed character streams checked against a layout predictor
`timescale 1ns / 1ps
`default_nettype none
module tb_text_line_measure_align_unit;

    localparam int FB        = 16;
    localparam int WDOG_MAX  = 20000;
    localparam int N_RANDOM  = 1250;

    // one character word as offered to the unit
    typedef struct {
        logic [1:0]         kind;
        logic [16:0]        sx;
        logic [16:0]        sy;
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [31:0] adv;
        logic               last;
    } t_char;

    // one result word
    typedef struct {
        logic               kind;
        logic signed [31:0] off;
        logic signed [31:0] x0;
        logic signed [31:0] y0;
        logic signed [31:0] x1;
        logic signed [31:0] y1;
        logic               last;
    } t_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [tlma_pkg::CFG_W-1:0] i_cfg_data;

    tlma_in_if  in_ch ();
    tlma_out_if out_ch ();

    text_line_measure_align_unit #(.FRAC_BITS(FB)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    // predictor copy of registers and layout state (64-bit signed for headroom)
    logic [1:0]         pm_align;
    longint             pm_size, pm_wf, pm_hf;
    longint             pen_x, pen_y, ln_left, ln_right;
    longint             bb_x0, bb_y0, bb_x1, bb_y1;

    t_char   char_queue[$];
    t_result layout_expected[$];
    int      n_errors, n_results, n_lines, n_boxes, n_chars;
    int      idle_pct;          // percent of cycles each side idles
    bit      hold_sink;         // long receiver hold-off in progress
    int      hold_cycles;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // floor division by 2^FB (>>> floors on signed values)
    function automatic longint drop_frac(longint v);
        return v >>> FB;
    endfunction

    function automatic longint by_size(longint v);
        return clamp32(drop_frac(v * pm_size));
    endfunction

    function automatic longint extent(logic [16:0] sc, longint factor);
        longint t;
        t = (longint'(sc) * factor) >>> 16;
        return clamp32(drop_frac(t * pm_size));
    endfunction

    function automatic longint shift_for(longint width);
        if (pm_align == tlma_pkg::ALIGN_RIGHT) return clamp32(-width);
        if (pm_align == tlma_pkg::ALIGN_CENTER) return clamp32(-(width / 2));
        return 0;
    endfunction

    function automatic void clear_layout();
        pen_x = 0; pen_y = 0; ln_left = 0; ln_right = 0;
        bb_x0 = 0; bb_y0 = 0; bb_x1 = 0; bb_y1 = 0;
    endfunction

    // advance the layout by one character, queue the words it must produce
    function automatic void predict_layout(t_char c);
        longint  gx, gy, w, h, x0, x1, y0, y1, step;
        bit      line_done;
        t_result r;
        line_done = 0;
        case (c.kind)
            tlma_pkg::KIND_GLYPH: begin
                gx = by_size(longint'(c.ox));
                gy = by_size(longint'(c.oy));
                w  = extent(c.sx, pm_wf);
                h  = extent(c.sy, pm_hf);
                x0 = clamp32(pen_x + gx); x1 = clamp32(x0 + w);
                y0 = clamp32(pen_y + gy); y1 = clamp32(y0 + h);
                if (x0 < ln_left) ln_left = x0;
                if (x1 > ln_right) ln_right = x1;
                if (x0 < bb_x0) bb_x0 = x0;
                if (x1 > bb_x1) bb_x1 = x1;
                if (y0 < bb_y0) bb_y0 = y0;
                if (y1 > bb_y1) bb_y1 = y1;
                pen_x = clamp32(pen_x + by_size(longint'(c.adv)));
                line_done = c.last;
            end
            tlma_pkg::KIND_NEWLINE: line_done = 1;
            tlma_pkg::KIND_TAB: begin
                step = pm_size * 2;
                // tab stop: next multiple of twice the size, truncating division
                if (step == 0) pen_x = 0;
                else pen_x = clamp32((pen_x / step + 1) * step);
            end
            default: ;
        endcase
        if (line_done) begin
            r = '{kind: tlma_pkg::RES_LINE, off: 32'(shift_for(ln_right - ln_left)),
                  x0: 0, y0: 0, x1: 0, y1: 0, last: !c.last};
            layout_expected = {layout_expected, r};
            if (c.kind == tlma_pkg::KIND_NEWLINE) begin
                ln_left = 0; ln_right = 0; pen_x = 0;
                pen_y = clamp32(pen_y + pm_size);
            end
        end
        if (c.last) begin
            step = shift_for(bb_x1 - bb_x0);
            r = '{kind: tlma_pkg::RES_BOX, off: 0, x0: 32'(clamp32(bb_x0 + step)),
                  y0: 32'(bb_y0), x1: 32'(clamp32(bb_x1 + step)),
                  y1: 32'(bb_y1), last: 1'b1};
            layout_expected = {layout_expected, r};
            clear_layout();
        end
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        n_errors++;
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    // driver: offers queued characters, idles at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            t_char c;
            logic  take, keep;
            take = in_ch.valid && in_ch.ready;
            if (take) begin
                predict_layout(char_queue.pop_front());
                n_chars++;
            end
            keep = in_ch.valid && !take;
            if (!keep) begin
                if (char_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    c = char_queue[0];
                    in_ch.valid          <= 1'b1;
                    in_ch.char_kind      <= c.kind;
                    in_ch.glyph_scale_x  <= c.sx;
                    in_ch.glyph_scale_y  <= c.sy;
                    in_ch.glyph_offset_x <= c.ox;
                    in_ch.glyph_offset_y <= c.oy;
                    in_ch.glyph_advance  <= c.adv;
                    in_ch.last_char      <= c.last;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls plus one long hold-off counted here
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            hold_cycles  <= 0;
        end else begin
            t_result e;
            if (out_ch.valid && out_ch.ready) begin
                n_results++;
                if (out_ch.result_kind == tlma_pkg::RES_LINE) n_lines++; else n_boxes++;
                if (layout_expected.size() == 0) begin
                    report_mismatch("unexpected word, kind", out_ch.result_kind, -1);
                end else begin
                    e = layout_expected.pop_front();
                    if (out_ch.result_kind !== e.kind)
                        report_mismatch("result_kind", out_ch.result_kind, e.kind);
                    if (out_ch.line_offset !== e.off)
                        report_mismatch("line_offset", out_ch.line_offset, e.off);
                    if (out_ch.box_min_x !== e.x0)
                        report_mismatch("box_min_x", out_ch.box_min_x, e.x0);
                    if (out_ch.box_min_y !== e.y0)
                        report_mismatch("box_min_y", out_ch.box_min_y, e.y0);
                    if (out_ch.box_max_x !== e.x1)
                        report_mismatch("box_max_x", out_ch.box_max_x, e.x1);
                    if (out_ch.box_max_y !== e.y1)
                        report_mismatch("box_max_y", out_ch.box_max_y, e.y1);
                    if (out_ch.last_result !== e.last)
                        report_mismatch("last_result", out_ch.last_result, e.last);
                end
            end
            if (hold_sink && hold_cycles < 400) begin
                hold_cycles  <= hold_cycles + 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    // watchdog: cycles without any accepted word or register write
    int quiet_cycles;
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WDOG_MAX) begin
            $display("watchdog: no progress, %0d words still expected",
                     layout_expected.size());
            $display("tb_text_line_measure_align_unit: errors");
            $finish;
        end
    end

    // random signed 32-bit value, mostly moderate, sometimes extreme
    function automatic logic signed [31:0] rand_metric();
        case ($urandom_range(9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $urandom;
            default: return 32'($signed($urandom_range(262143)) - 32'sd65536);
        endcase
    endfunction

    function automatic t_char make_char(logic [1:0] kind, logic last);
        t_char c;
        c.kind = kind;
        c.sx   = ($urandom_range(7) == 0) ? 17'h10000 : 17'($urandom_range(65536));
        c.sy   = ($urandom_range(7) == 0) ? 17'h10000 : 17'($urandom_range(65536));
        if ($urandom_range(15) == 0) c.sx = 17'($urandom); // all bits of the field
        if ($urandom_range(15) == 0) c.sy = 17'($urandom);
        c.ox   = rand_metric();
        c.oy   = rand_metric();
        c.adv  = rand_metric();
        c.last = last;
        return c;
    endfunction

    // a text: a run of characters, mostly glyphs, ending on a last-flagged item
    task automatic queue_text(input int len);
        logic [1:0] k;
        int u;
        for (int i = 0; i < len; i++) begin
            u = $urandom_range(99);
            if (u < 65) k = tlma_pkg::KIND_GLYPH;
            else if (u < 80) k = tlma_pkg::KIND_NEWLINE;
            else if (u < 92) k = tlma_pkg::KIND_TAB;
            else k = tlma_pkg::KIND_MISSING;
            char_queue = {char_queue, make_char(k, i == len - 1)};
        end
    endtask

    task automatic wait_drained();
        while (char_queue.size() > 0 || in_ch.valid || layout_expected.size() > 0)
            @(posedge i_clk);
        // a tab or missing glyph can still be in flight with nothing expected
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(input tlma_pkg::t_cfg_index idx,
                             input logic [tlma_pkg::CFG_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            tlma_pkg::CFG_ALIGN_MODE:   pm_align = v[1:0];
            tlma_pkg::CFG_TEXT_SIZE:    pm_size  = longint'(v);
            tlma_pkg::CFG_WIDTH_FACTOR: pm_wf    = longint'(v);
            default:                    pm_hf    = longint'(v);
        endcase
    endtask

    initial begin
        t_char c;
        int    phase_items;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = tlma_pkg::CFG_ALIGN_MODE;
        i_cfg_data  = '0;
        in_ch.valid = 1'b0;
        in_ch.char_kind = tlma_pkg::KIND_GLYPH;
        in_ch.glyph_scale_x = '0; in_ch.glyph_scale_y = '0;
        in_ch.glyph_offset_x = '0; in_ch.glyph_offset_y = '0;
        in_ch.glyph_advance = '0; in_ch.last_char = 1'b0;
        out_ch.ready = 1'b0;
        n_errors = 0; n_results = 0; n_lines = 0; n_boxes = 0; n_chars = 0;
        idle_pct = 21; hold_sink = 0;
        pm_align = tlma_pkg::ALIGN_LEFT; pm_size = 64'd16 << FB;
        pm_wf = 64'd1 << FB; pm_hf = 64'd1 << FB;
        clear_layout();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset settings, field extremes, every kind, final tab and missing glyph
        c = '{kind: tlma_pkg::KIND_GLYPH, sx: 17'h10000, sy: 17'h10000, ox: 32'sh7FFF_FFFF,
              oy: 32'sh8000_0000, adv: 32'sh7FFF_FFFF, last: 0};
        char_queue = {char_queue, c};
        c = '{kind: tlma_pkg::KIND_GLYPH, sx: 17'h1FFFF, sy: 0, ox: 32'sh8000_0000,
              oy: 32'sh7FFF_FFFF, adv: 32'sh8000_0000, last: 0};
        char_queue = {char_queue, c};
        char_queue = {char_queue, make_char(tlma_pkg::KIND_TAB, 0)};
        char_queue = {char_queue, make_char(tlma_pkg::KIND_MISSING, 0)};
        char_queue = {char_queue, make_char(tlma_pkg::KIND_NEWLINE, 0)};
        char_queue = {char_queue, make_char(tlma_pkg::KIND_GLYPH, 1)};
        char_queue = {char_queue, make_char(tlma_pkg::KIND_TAB, 1)};
        char_queue = {char_queue, make_char(tlma_pkg::KIND_MISSING, 1)};
        char_queue = {char_queue, make_char(tlma_pkg::KIND_NEWLINE, 1)};
        wait_drained();

        // extremes of the registers, the right, center and undefined align modes
        write_reg(tlma_pkg::CFG_ALIGN_MODE, tlma_pkg::CFG_W'(tlma_pkg::ALIGN_RIGHT));
        write_reg(tlma_pkg::CFG_TEXT_SIZE, 26'h3FF_FFFF);
        write_reg(tlma_pkg::CFG_WIDTH_FACTOR, 26'h3FF_FFFF);
        write_reg(tlma_pkg::CFG_HEIGHT_FACTOR, 26'h3FF_FFFF);
        queue_text(6);
        wait_drained();
        write_reg(tlma_pkg::CFG_ALIGN_MODE, tlma_pkg::CFG_W'(tlma_pkg::ALIGN_CENTER));
        write_reg(tlma_pkg::CFG_TEXT_SIZE, '0);  // zero size: tab drops the pen to zero
        write_reg(tlma_pkg::CFG_WIDTH_FACTOR, '0);
        write_reg(tlma_pkg::CFG_HEIGHT_FACTOR, '0);
        char_queue = {char_queue, make_char(tlma_pkg::KIND_GLYPH, 0)};
        char_queue = {char_queue, make_char(tlma_pkg::KIND_TAB, 0)};
        char_queue = {char_queue, make_char(tlma_pkg::KIND_GLYPH, 1)};
        wait_drained();
        write_reg(tlma_pkg::CFG_ALIGN_MODE, tlma_pkg::CFG_W'(tlma_pkg::ALIGN_UNDEF));
        write_reg(tlma_pkg::CFG_TEXT_SIZE, 26'd1 << FB);
        queue_text(5);
        wait_drained();

        // random phases over several settings; one phase without idling
        for (int p = 0; p < 8; p++) begin
            write_reg(tlma_pkg::CFG_ALIGN_MODE, tlma_pkg::CFG_W'($urandom_range(3)));
            write_reg(tlma_pkg::CFG_TEXT_SIZE,
                      (p == 5) ? 26'h3FF_FFFF : 26'($urandom_range(1 << 21)));
            write_reg(tlma_pkg::CFG_WIDTH_FACTOR, 26'($urandom_range(1 << 18)));
            write_reg(tlma_pkg::CFG_HEIGHT_FACTOR, 26'($urandom_range(1 << 18)));
            idle_pct = (p == 3) ? 0 : 21;
            phase_items = 0;
            while (phase_items < N_RANDOM / 8) begin
                int len;
                len = $urandom_range(12, 1);
                if ($urandom_range(9) == 0) begin
                    // noise: loose characters with random last flags
                    for (int j = 0; j < len; j++)
                        char_queue = {char_queue,
                                      make_char(2'($urandom), $urandom_range(3) == 0)};
                end else begin
                    queue_text(len);
                end
                phase_items += len;
            end
            if (p == 2) begin
                // receiver holds off while the sender keeps offering
                hold_sink = 1;
                while (hold_cycles < 400) @(posedge i_clk);
                hold_sink = 0;
            end
            wait_drained();   // sender pause until every expected word has come
        end

        $display("covered %0d characters, %0d result words (%0d line offsets, %0d boxes)",
                 n_chars, n_results, n_lines, n_boxes);
        $display("all align modes, register extremes, zero size tabs and a long receiver stall");
        if (n_errors == 0 && layout_expected.size() == 0) begin
            $display("tb_text_line_measure_align_unit: clean");
        end else begin
            $display("%0d mismatches, %0d words never came", n_errors, layout_expected.size());
            $display("tb_text_line_measure_align_unit: errors");
        end
        $finish;
    end

endmodule
`default_nettype wire
